>>> hdl/cdda_pkg.sv
package cdda_pkg;

  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [YearW-1:0] YearLow  = 12'd1752;
  localparam logic [YearW-1:0] YearHigh = 12'd2080;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthApr = 4'd4;
  localparam logic [MonthW-1:0] MonthJun = 4'd6;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthNov = 4'd11;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] DayFirst = 5'd1;
  localparam logic [DayW-1:0] DayMax   = 5'd31;

  localparam logic OpSet = 1'b0;
  localparam logic OpAdd = 1'b1;

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StYear  = 3'd1,
    StDay   = 3'd2,
    StLapse = 3'd3,
    StUnder = 3'd4,
    StOver  = 3'd5
  } status_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    status_e           status;
    logic              done;
  } step_res_t;

  // century rule only needs the years the block can hold
  function automatic logic [DayW-1:0] month_len(logic [MonthW-1:0] m, logic [YearW-1:0] y);
    logic            leap;
    logic [DayW-1:0] len;
    leap = (y[1:0] == 2'b00) && (y != 12'd1800) && (y != 12'd1900) && (y != 12'd2100);
    unique case (m) inside
      MonthFeb:                               len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default:                                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> hdl/calendar_date_day_adder_unit.sv
// Holds a Gregorian date (reset 1752-09-08) and takes one command per transfer: a set loads a
// checked date, an add moves the date by a signed day count of at most MaxLapse days, one day per
// cycle through a shared step unit. Each command goes from the input transfer through the StStep
// and StFin states into the output register; an add steps the date in StStep. The input
// is taken again once the result sits in the output register, even before it is transferred out.
// Any error leaves the stored date unchanged, and each result reports the stored date and a status.
module calendar_date_day_adder_unit #(
  parameter int unsigned MaxLapse = 500
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [11:0]                 set_year_i,
  input  logic [3:0]                  set_month_i,
  input  logic [4:0]                  set_day_i,
  input  logic signed [10:0]          day_delta_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [11:0]                 cur_year_o,
  output logic [3:0]                  cur_month_o,
  output logic [4:0]                  cur_day_o,
  output logic [2:0]                  status_o
);

  localparam int unsigned CntW = $clog2(MaxLapse + 1);
  localparam logic signed [11:0] LapseLim = 12'(MaxLapse);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StStep = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic                        op_q, op_d;
  logic                        dir_q, dir_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [11:0]                 wy_q, wy_d;
  logic [3:0]                  wm_q, wm_d;
  logic [4:0]                  wd_q, wd_d;
  cdda_pkg::status_e           st_q, st_d;
  logic [11:0]                 year_q;
  logic [3:0]                  month_q;
  logic [4:0]                  day_q;
  logic                        out_valid_q, out_valid_d;
  logic [11:0]                 out_year_q;
  logic [3:0]                  out_month_q;
  logic [4:0]                  out_day_q;
  cdda_pkg::status_e           out_st_q;

  logic signed [11:0]          delta_ext;
  logic [11:0]                 delta_mag;
  logic                        lapse_err;
  logic                        in_xfer;
  logic                        fin_go;
  logic                        commit;
  cdda_pkg::step_res_t         res;

  assign delta_ext = 12'(day_delta_i);
  assign delta_mag = delta_ext[11] ? 12'(-delta_ext) : 12'(delta_ext);
  assign lapse_err = (delta_ext > LapseLim) || (delta_ext < -LapseLim);

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign fin_go     = (state_q == StFin) && (!out_valid_q || out_ready_i);
  assign commit     = fin_go && (st_q == cdda_pkg::StOk);

  cdda_step u_step (
    .op_i       (op_q),
    .dir_i      (dir_q),
    .cnt_zero_i (cnt_q == '0),
    .year_i     (wy_q),
    .month_i    (wm_q),
    .day_i      (wd_q),
    .res_o      (res)
  );

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    dir_d   = dir_q;
    cnt_d   = cnt_q;
    wy_d    = wy_q;
    wm_d    = wm_q;
    wd_d    = wd_q;
    st_d    = st_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          op_d    = op_i;
          dir_d   = delta_ext[11];
          cnt_d   = delta_mag[CntW-1:0];
          state_d = StStep;
          if (op_i == cdda_pkg::OpSet) begin
            wy_d = set_year_i;
            wm_d = set_month_i;
            wd_d = set_day_i;
            st_d = cdda_pkg::StOk;
          end else begin
            wy_d = year_q;
            wm_d = month_q;
            wd_d = day_q;
            st_d = lapse_err ? cdda_pkg::StLapse : cdda_pkg::StOk;
          end
        end
      end
      StStep: begin
        if (st_q != cdda_pkg::StOk) begin
          state_d = StFin;
        end else begin
          wy_d  = res.year;
          wm_d  = res.month;
          wd_d  = res.day;
          st_d  = res.status;
          cnt_d = cnt_q - CntW'(1);
          if (res.done) begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        if (fin_go) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      year_q      <= cdda_pkg::YearLow;
      month_q     <= cdda_pkg::MonthSep;
      day_q       <= 5'd8;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        year_q  <= wy_q;
        month_q <= wm_q;
        day_q   <= wd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    dir_q <= dir_d;
    cnt_q <= cnt_d;
    wy_q  <= wy_d;
    wm_q  <= wm_d;
    wd_q  <= wd_d;
    st_q  <= st_d;
    if (fin_go) begin
      out_year_q  <= commit ? wy_q : year_q;
      out_month_q <= commit ? wm_q : month_q;
      out_day_q   <= commit ? wd_q : day_q;
      out_st_q    <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cur_year_o  = out_year_q;
  assign cur_month_o = out_month_q;
  assign cur_day_o   = out_day_q;
  assign status_o    = out_st_q;

endmodule

>>> hdl/cdda_step.sv
module cdda_step (
  input  logic                          op_i,
  input  logic                          dir_i,
  input  logic                          cnt_zero_i,
  input  logic [cdda_pkg::YearW-1:0]    year_i,
  input  logic [cdda_pkg::MonthW-1:0]   month_i,
  input  logic [cdda_pkg::DayW-1:0]     day_i,
  output cdda_pkg::step_res_t           res_o
);

  logic [cdda_pkg::MonthW-1:0] lk_month;
  logic [cdda_pkg::DayW-1:0]   len;

  // backward steps need the length of the previous month
  assign lk_month = (op_i == cdda_pkg::OpAdd && dir_i) ? month_i - 4'd1 : month_i;
  assign len      = cdda_pkg::month_len(lk_month, year_i);

  always_comb begin
    res_o.year   = year_i;
    res_o.month  = month_i;
    res_o.day    = day_i;
    res_o.status = cdda_pkg::StOk;
    res_o.done   = 1'b0;
    if (op_i == cdda_pkg::OpSet) begin
      res_o.done = 1'b1;
      if (year_i <= cdda_pkg::YearLow || year_i > cdda_pkg::YearHigh) begin
        res_o.status = cdda_pkg::StYear;
      end else if (month_i < cdda_pkg::MonthJan || month_i > cdda_pkg::MonthDec) begin
        res_o.status = cdda_pkg::StDay;
      end else if (day_i < cdda_pkg::DayFirst || day_i > len) begin
        res_o.status = cdda_pkg::StDay;
      end
    end else if (cnt_zero_i) begin
      res_o.done = 1'b1;
    end else if (!dir_i) begin
      if (day_i >= len) begin
        res_o.day = cdda_pkg::DayFirst;
        if (month_i == cdda_pkg::MonthDec) begin
          if (year_i >= cdda_pkg::YearHigh - 12'd1) begin
            res_o.status = cdda_pkg::StOver;
            res_o.done   = 1'b1;
          end
          res_o.year  = year_i + 12'd1;
          res_o.month = cdda_pkg::MonthJan;
        end else begin
          res_o.month = month_i + 4'd1;
        end
      end else begin
        res_o.day = day_i + 5'd1;
      end
    end else begin
      if (day_i <= cdda_pkg::DayFirst) begin
        if (month_i <= cdda_pkg::MonthJan) begin
          if (year_i <= cdda_pkg::YearLow + 12'd1) begin
            res_o.status = cdda_pkg::StUnder;
            res_o.done   = 1'b1;
          end
          res_o.year  = year_i - 12'd1;
          res_o.month = cdda_pkg::MonthDec;
          res_o.day   = cdda_pkg::DayMax;
        end else begin
          res_o.month = lk_month;
          res_o.day   = len;
        end
      end else begin
        res_o.day = day_i - 5'd1;
      end
    end
  end

endmodule
